[rtl/mia_pkg.sv]
// ---------------------------------------------------------------------------
// mia_pkg: shared types and constants for the mean inscribed angle block
// Holds the CORDIC arctangent table, datapath widths and result status codes.
// ---------------------------------------------------------------------------
package mia_pkg;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 31;
	localparam int STEP_W       = 5;
	localparam int WORK_W       = 62;   // holds a prescaled vector plus gain growth
	localparam int PRESCALE_TOP = 58;   // vector is scaled by 2^(58 - coordinate bits)
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	// Port field widths
	localparam int FIELD_W    = 16;
	localparam int COUNT_W    = 10;
	localparam int STATUS_W   = 2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
		logic [31:0] val;
		unique case (idx)
			5'd0:    val = 32'h2000_0000;
			5'd1:    val = 32'h12E4_051E;
			5'd2:    val = 32'h09FB_385B;
			5'd3:    val = 32'h0511_11D4;
			5'd4:    val = 32'h028B_0D43;
			5'd5:    val = 32'h0145_D7E1;
			5'd6:    val = 32'h00A2_F61E;
			5'd7:    val = 32'h0051_7C55;
			5'd8:    val = 32'h0028_BE53;
			5'd9:    val = 32'h0014_5F2F;
			5'd10:   val = 32'h000A_2F98;
			5'd11:   val = 32'h0005_17CC;
			5'd12:   val = 32'h0002_8BE6;
			5'd13:   val = 32'h0001_45F3;
			5'd14:   val = 32'h0000_A2FA;
			5'd15:   val = 32'h0000_517D;
			5'd16:   val = 32'h0000_28BE;
			5'd17:   val = 32'h0000_145F;
			5'd18:   val = 32'h0000_0A30;
			5'd19:   val = 32'h0000_0518;
			5'd20:   val = 32'h0000_028C;
			5'd21:   val = 32'h0000_0146;
			5'd22:   val = 32'h0000_00A3;
			5'd23:   val = 32'h0000_0051;
			5'd24:   val = 32'h0000_0029;
			5'd25:   val = 32'h0000_0014;
			5'd26:   val = 32'h0000_000A;
			5'd27:   val = 32'h0000_0005;
			5'd28:   val = 32'h0000_0003;
			5'd29:   val = 32'h0000_0001;
			5'd30:   val = 32'h0000_0001;
			default: val = 32'h0000_0000;
		endcase
		return val;
	endfunction

endpackage

[rtl/mia_cordic.sv]
// ---------------------------------------------------------------------------
// mia_cordic: iterative vectoring CORDIC for the direction of a vector
// One micro-rotation per cycle; returns the angle in binary angle units.
// ---------------------------------------------------------------------------
module mia_cordic #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS:0]   dx,
	input  logic signed [COORD_BITS:0]   dy,
	output logic                         done,
	output logic [ANGLE_BITS-1:0]        angle
);

	localparam int W        = mia_pkg::WORK_W;
	localparam int PRESCALE = mia_pkg::PRESCALE_TOP - COORD_BITS;
	localparam logic [31:0] ROUND = 32'(64'd1 << (31 - ANGLE_BITS));
	localparam logic [mia_pkg::STEP_W-1:0] LAST_STEP =
		mia_pkg::STEP_W'(mia_pkg::CORDIC_STEPS - 1);

	typedef enum logic {CS_IDLE, CS_RUN} cstate_t;

	cstate_t                      state_q;
	logic [mia_pkg::STEP_W-1:0]   step_q;
	logic signed [W-1:0]          x_q, y_q;
	logic [31:0]                  z_q;
	logic                         done_q;
	logic [ANGLE_BITS-1:0]        angle_q;

	// prescaled start vector, folded into the right half plane
	logic signed [W-1:0] x_scl, y_scl;
	logic                is_zero;
	assign x_scl   = W'(dx) <<< PRESCALE;
	assign y_scl   = W'(dy) <<< PRESCALE;
	assign is_zero = (dx == '0) && (dy == '0);

	// one micro-rotation
	logic signed [W-1:0] sh_x, sh_y, x_n, y_n;
	logic [31:0]         z_n, z_rnd, atan_i;
	logic                y_pos;
	assign sh_x   = x_q >>> step_q;
	assign sh_y   = y_q >>> step_q;
	assign y_pos  = !y_q[W-1] && (y_q != '0);
	assign atan_i = mia_pkg::atan_turn(step_q);
	assign x_n    = y_pos ? x_q + sh_y : x_q - sh_y;
	assign y_n    = y_pos ? y_q - sh_x : y_q + sh_x;
	assign z_n    = y_pos ? z_q + atan_i : z_q - atan_i;
	assign z_rnd  = z_n + ROUND;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			done_q  <= 1'b0;
			angle_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				CS_IDLE: begin
					if (start) begin
						step_q <= '0;
						if (is_zero) begin
							// repeated point: direction zero
							angle_q <= '0;
							done_q  <= 1'b1;
						end else if (x_scl[W-1]) begin
							x_q     <= -x_scl;
							y_q     <= -y_scl;
							z_q     <= mia_pkg::HALF_TURN;
							state_q <= CS_RUN;
						end else begin
							x_q     <= x_scl;
							y_q     <= y_scl;
							z_q     <= '0;
							state_q <= CS_RUN;
						end
					end
				end
				CS_RUN: begin
					x_q    <= x_n;
					y_q    <= y_n;
					z_q    <= z_n;
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						angle_q <= z_rnd[31 -: ANGLE_BITS];
						done_q  <= 1'b1;
						state_q <= CS_IDLE;
					end
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

[rtl/mia_div.sv]
// ---------------------------------------------------------------------------
// mia_div: iterative signed divider, quotient truncated toward zero
// Restoring division on the magnitude, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mia_div #(
	parameter int NUM_W = 27,
	parameter int DEN_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quot
);

	localparam int IDX_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(NUM_W - 1);

	typedef enum logic {DS_IDLE, DS_RUN} dstate_t;

	dstate_t            state_q;
	logic [IDX_W-1:0]   bit_q;
	logic [NUM_W-1:0]   mag_q;     // dividend bits shift out, quotient bits shift in
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic               neg_q;
	logic               done_q;

	// trial subtract
	logic [DEN_W:0] trial, diff;
	logic           fits;
	assign trial = {rem_q, mag_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			bit_q   <= '0;
			mag_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (start) begin
						mag_q   <= num[NUM_W-1] ? (~num + 1'b1) : num;
						neg_q   <= num[NUM_W-1];
						den_q   <= den;
						rem_q   <= '0;
						bit_q   <= '0;
						state_q <= DS_RUN;
					end
				end
				DS_RUN: begin
					rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					mag_q  <= {mag_q[NUM_W-2:0], fits};
					bit_q  <= bit_q + 1'b1;
					if (bit_q == LAST_BIT) begin
						done_q  <= 1'b1;
						state_q <= DS_IDLE;
					end
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

[rtl/mean_inscribed_angle.sv]
// ---------------------------------------------------------------------------
// mean_inscribed_angle: mean inscribed angle of one laser scan segment
// Each point from the third on, while the segment has room, takes two 31-step
// runs of the shared CORDIC unit plus sequencing; the first two points need no
// CORDIC run. The last point of a segment of three or more points also runs the
// bit-serial divider before the result item is shown on the master side.
// Points are taken one at a time: s_tready is high only while idle.
// Reset: segment state, sequencer and output valid clear at once; no sweep.
// ---------------------------------------------------------------------------
module mean_inscribed_angle #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] point_x, [31:16] point_y
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] mean_angle, [25:16] angle_count, [31:26] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = ANGLE_BITS + $clog2(MAX_POINTS) + 1;
	localparam int FW    = mia_pkg::FIELD_W;
	localparam int CW    = mia_pkg::COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BACK, ST_FWD, ST_FIN, ST_DIV, ST_EMIT
	} state_t;

	state_t                        state_q;
	logic signed [COORD_BITS-1:0]  x_q, y_q;
	logic                          last_q;
	logic signed [COORD_BITS-1:0]  prev0_x_q, prev0_y_q, prev1_x_q, prev1_y_q;
	logic [CNT_W-1:0]              points_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic                          overflowed_q;
	logic [ANGLE_BITS-1:0]         back_q;
	logic [FW-1:0]                 res_mean_q, mean_out_q;
	logic [CW-1:0]                 res_cnt_q, cnt_out_q;
	logic [mia_pkg::STATUS_W-1:0]  res_status_q, status_out_q;
	logic                          m_tvalid_q;

	// input fields at coordinate width
	logic signed [COORD_BITS-1:0] in_x, in_y;
	logic                         s_accept;
	assign in_x     = COORD_BITS'(s_tdata[15:0]);
	assign in_y     = COORD_BITS'(s_tdata[31:16]);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// segment bookkeeping
	logic has_room, need_angle, enough;
	assign has_room   = points_q < CNT_W'(MAX_POINTS);
	assign need_angle = has_room && (points_q >= CNT_W'(2));
	assign enough     = points_q >= CNT_W'(3);

	// shared CORDIC: backward vector at accept, forward vector after it
	logic                       c_start, c_done;
	logic signed [COORD_BITS:0] c_dx, c_dy;
	logic [ANGLE_BITS-1:0]      c_angle;
	assign c_start = (s_accept && need_angle) || ((state_q == ST_BACK) && c_done);
	always_comb begin
		if (state_q == ST_IDLE) begin
			c_dx = {prev1_x_q[COORD_BITS-1], prev1_x_q} - {prev0_x_q[COORD_BITS-1], prev0_x_q};
			c_dy = {prev1_y_q[COORD_BITS-1], prev1_y_q} - {prev0_y_q[COORD_BITS-1], prev0_y_q};
		end else begin
			c_dx = {x_q[COORD_BITS-1], x_q} - {prev0_x_q[COORD_BITS-1], prev0_x_q};
			c_dy = {y_q[COORD_BITS-1], y_q} - {prev0_y_q[COORD_BITS-1], prev0_y_q};
		end
	end

	mia_cordic #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (c_start),
		.dx    (c_dx),
		.dy    (c_dy),
		.done  (c_done),
		.angle (c_angle)
	);

	// inscribed angle, wrapped to a signed half turn
	logic [ANGLE_BITS-1:0] a_diff;
	assign a_diff = c_angle - back_q;

	// divider for the segment mean
	logic                    d_start, d_done;
	logic [CNT_W-1:0]        n_angles;
	logic signed [SUM_W-1:0] d_quot;
	assign d_start  = (state_q == ST_FIN) && last_q && enough;
	assign n_angles = points_q - CNT_W'(2);

	mia_div #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (d_start),
		.num   (sum_q),
		.den   (n_angles),
		.done  (d_done),
		.quot  (d_quot)
	);

	// zero-extended views for the output fields
	logic [39:0] mean_ext;
	logic [31:0] n_ext;
	assign mean_ext = 40'(d_quot[ANGLE_BITS-1:0]);
	assign n_ext    = 32'(n_angles);

	// sequencer, segment state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			x_q          <= '0;
			y_q          <= '0;
			last_q       <= 1'b0;
			prev0_x_q    <= '0;
			prev0_y_q    <= '0;
			prev1_x_q    <= '0;
			prev1_y_q    <= '0;
			points_q     <= '0;
			sum_q        <= '0;
			overflowed_q <= 1'b0;
			back_q       <= '0;
			res_mean_q   <= '0;
			res_cnt_q    <= '0;
			res_status_q <= mia_pkg::STATUS_OK;
			mean_out_q   <= '0;
			cnt_out_q    <= '0;
			status_out_q <= mia_pkg::STATUS_OK;
			m_tvalid_q   <= 1'b0;
		end else begin
			// drop valid on handshake unless a new item is loaded this cycle
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						x_q    <= in_x;
						y_q    <= in_y;
						last_q <= s_tlast;
						if (need_angle) begin
							state_q <= ST_BACK;
						end else begin
							if (has_room) begin
								prev1_x_q <= prev0_x_q;
								prev1_y_q <= prev0_y_q;
								prev0_x_q <= in_x;
								prev0_y_q <= in_y;
								points_q  <= points_q + 1'b1;
							end else begin
								overflowed_q <= 1'b1;
							end
							state_q <= ST_FIN;
						end
					end
				end
				ST_BACK: begin
					if (c_done) begin
						back_q  <= c_angle;
						state_q <= ST_FWD;
					end
				end
				ST_FWD: begin
					if (c_done) begin
						sum_q     <= sum_q + SUM_W'($signed(a_diff));
						prev1_x_q <= prev0_x_q;
						prev1_y_q <= prev0_y_q;
						prev0_x_q <= x_q;
						prev0_y_q <= y_q;
						points_q  <= points_q + 1'b1;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (!enough) begin
						// short segment: flag only
						res_mean_q   <= '0;
						res_cnt_q    <= '0;
						res_status_q <= mia_pkg::STATUS_SHORT;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (d_done) begin
						res_mean_q   <= mean_ext[FW-1:0];
						res_cnt_q    <= n_ext[CW-1:0];
						res_status_q <= overflowed_q ? mia_pkg::STATUS_OVER
						                             : mia_pkg::STATUS_OK;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						mean_out_q   <= res_mean_q;
						cnt_out_q    <= res_cnt_q;
						status_out_q <= res_status_q;
						m_tvalid_q   <= 1'b1;
						prev0_x_q    <= '0;
						prev0_y_q    <= '0;
						prev1_x_q    <= '0;
						prev1_y_q    <= '0;
						points_q     <= '0;
						sum_q        <= '0;
						overflowed_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, cnt_out_q, mean_out_q};
	assign m_tuser  = status_out_q;

	// checks
	a_points_cap: assert property (@(posedge clk) disable iff (!arst_n)
		points_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == mia_pkg::STATUS_SHORT) |-> (m_tdata[25:0] == 26'd0))
		else $error("short segment result carries data");

	a_seg_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (points_q == '0) && (sum_q == '0) && !overflowed_q)
		else $error("segment state not cleared with result");

	a_cordic_owner: assert property (@(posedge clk) disable iff (!arst_n)
		c_done |-> (state_q == ST_BACK) || (state_q == ST_FWD))
		else $error("CORDIC finished outside an angle step");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> enough && $stable(points_q))
		else $error("divider running on a short segment");

endmodule
